// ----- hdl/sbl_pkg.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// sbl_pkg
// shared sizes, register codes and the window entry type of the sobel core
// ---------------------------------------------------------------------------
package sbl_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;

    // counter and clamped size widths follow the maximum frame size
    localparam int COL_W    = $clog2(MAX_WIDTH);
    localparam int ROW_W    = $clog2(MAX_HEIGHT);
    localparam int WSIZE_W  = $clog2(MAX_WIDTH + 1);
    localparam int HSIZE_W  = $clog2(MAX_HEIGHT + 1);

    // fixed field widths
    localparam int PIX_W    = 8;
    localparam int GRAD_W   = 11;
    localparam int POS_W    = 10;
    localparam int CFG_W    = 11;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

    localparam logic [CFG_W-1:0] FRAME_WIDTH_RST  = 11'd640;
    localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = 11'd480;

    // queue between front and back
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef struct packed {
        logic [WSIZE_W-1:0] width;
        logic [HSIZE_W-1:0] height;
    } sbl_size_t;

    // one complete window minus its center, plus position and frame end
    typedef struct packed {
        logic [PIX_W-1:0] p00;
        logic [PIX_W-1:0] p01;
        logic [PIX_W-1:0] p02;
        logic [PIX_W-1:0] p10;
        logic [PIX_W-1:0] p12;
        logic [PIX_W-1:0] p20;
        logic [PIX_W-1:0] p21;
        logic [PIX_W-1:0] p22;
        logic [POS_W-1:0] col;
        logic [POS_W-1:0] row;
        logic             last;
    } sbl_win_t;

    function automatic logic [WSIZE_W-1:0] clamp_width(input logic [CFG_W-1:0] v);
        logic [31:0] v32;
        logic [31:0] r;
        v32 = 32'(v);
        if (v32 < 32'd3)
            r = 32'd3;
        else if (v32 > 32'(MAX_WIDTH))
            r = 32'(MAX_WIDTH);
        else
            r = v32;
        return WSIZE_W'(r);
    endfunction

    function automatic logic [HSIZE_W-1:0] clamp_height(input logic [CFG_W-1:0] v);
        logic [31:0] v32;
        logic [31:0] r;
        v32 = 32'(v);
        if (v32 < 32'd3)
            r = 32'd3;
        else if (v32 > 32'(MAX_HEIGHT))
            r = 32'(MAX_HEIGHT);
        else
            r = v32;
        return HSIZE_W'(r);
    endfunction

endpackage
`default_nettype wire

// ----- hdl/sobel_gradient_3x3_core.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// sobel_gradient_3x3_core
// streaming 3x3 sobel gradient on 8-bit grayscale pixels in raster order
// ---------------------------------------------------------------------------
//  channel   dir  handshake           payload
//  s_*       in   s_tvalid/s_tready   s_tdata pixel, s_tuser frame start
//  m_*       out  m_tvalid/m_tready   m_tdata gradients and position, m_tlast
//  cfg_*     in   cfg_we              cfg_index, cfg_wdata (no read-back)
//
//  one pixel word per clock while s_tready is high; a gradient word passes
//  the line store read (on the edge that takes the pixel completing its
//  window), then the queue write, then the output register, which an
//  output stall can delay; border pixels give no output word
//  throughput is set by the line store, one read port and one write port
//  used each clock, and the one-word output register
//  reset: counters at row 0 column 0, width 640, height 480; the line store
//  has no clearing pass, entries are written in rows 0 and 1 before use
//  output stalls fill the four-word queue; s_tready drops once queued words
//  plus a pending push reach four
// ---------------------------------------------------------------------------
module sobel_gradient_3x3_core
    import sbl_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    // pixel stream
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [7:0]           s_tdata,   // [7:0] pixel
    input  wire logic                 s_tuser,   // [0] frame_start
    // gradient stream
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [47:0]               m_tdata,   // [10:0] grad_x, [21:11] grad_y,
                                                 // [31:22] out_col, [41:32] out_row
    output logic                      m_tlast,   // last_of_frame
    // configuration
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_wdata
);

    logic [CFG_W-1:0]  frame_width_reg;
    logic [CFG_W-1:0]  frame_height_reg;
    sbl_size_t         size;

    logic              push;
    sbl_win_t          push_data;
    logic              pop;
    logic              q_valid;
    sbl_win_t          q_data;
    logic [QCNT_W-1:0] q_count;

    // register file; unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= FRAME_WIDTH_RST;
            frame_height_reg <= FRAME_HEIGHT_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_FRAME_WIDTH:  frame_width_reg  <= cfg_wdata;
                REG_FRAME_HEIGHT: frame_height_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // sizes in use are clamped to 3..max
    assign size.width  = clamp_width(frame_width_reg);
    assign size.height = clamp_height(frame_height_reg);

    // front: counters, line store and window
    sbl_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .size      (size),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .q_count   (q_count),
        .push      (push),
        .push_data (push_data)
    );

    // decoupling queue of complete windows
    sbl_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .q_valid   (q_valid),
        .q_data    (q_data),
        .q_count   (q_count)
    );

    // back: gradient math and output register
    sbl_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_data   (q_data),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule
`default_nettype wire

// ----- hdl/sbl_front.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// sbl_front
// pixel intake: position counters, line store, 3x3 window, window push
// ---------------------------------------------------------------------------
module sbl_front
    import sbl_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire sbl_size_t         size,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [PIX_W-1:0]  s_tdata,
    input  wire logic              s_tuser,
    input  wire logic [QCNT_W-1:0] q_count,
    output logic                   push,
    output sbl_win_t               push_data
);

    logic             in_fire;
    logic [COL_W-1:0] col_cur;
    logic [ROW_W-1:0] row_cur;
    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;

    // stage 1: item whose line store read is in flight
    logic             s1_valid_reg;
    logic [COL_W-1:0] s1_col_reg;
    logic [ROW_W-1:0] s1_row_reg;
    logic [PIX_W-1:0] s1_px_reg;

    // line store: upper row in the high byte, middle row in the low byte
    logic [2*PIX_W-1:0] ls_mem [MAX_WIDTH];
    logic [2*PIX_W-1:0] rd_reg;
    logic               byp_hit_reg;
    logic [2*PIX_W-1:0] byp_data_reg;
    logic [2*PIX_W-1:0] ls_word;
    logic [2*PIX_W-1:0] wr_word;

    logic [2:0][2:0][PIX_W-1:0] win_reg, win_next;
    logic                       emit;
    logic [COL_W-1:0]           col_m1;
    logic [ROW_W-1:0]           row_m1;

    assign in_fire = s_tvalid && s_tready;

    // room for the word in stage 1 and the one taken now
    assign s_tready = (32'(q_count) + 32'(push)) < 32'(QDEPTH);

    always_comb
    begin
        col_cur = s_tuser ? '0 : col_reg;
        row_cur = s_tuser ? '0 : row_reg;
        if (32'(col_cur) + 32'd1 >= 32'(size.width))
        begin
            col_next = '0;
            if (32'(row_cur) + 32'd1 >= 32'(size.height))
                row_next = '0;
            else
                row_next = row_cur + 1'b1;
        end
        else
        begin
            col_next = col_cur + 1'b1;
            row_next = row_cur;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= in_fire;
            if (in_fire)
            begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_col_reg <= col_cur;
            s1_row_reg <= row_cur;
            s1_px_reg  <= s_tdata;
        end
    end

    // read on intake, write back in the following cycle; same column forwards
    assign ls_word = byp_hit_reg ? byp_data_reg : rd_reg;
    assign wr_word = {ls_word[PIX_W-1:0], s1_px_reg};

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            rd_reg       <= ls_mem[col_cur];
            byp_hit_reg  <= s1_valid_reg && (s1_col_reg == col_cur);
            byp_data_reg <= wr_word;
        end
        if (s1_valid_reg)
            ls_mem[s1_col_reg] <= wr_word;
    end

    always_comb
    begin
        win_next = win_reg;
        for (int r = 0; r < 3; r++)
        begin
            win_next[r][0] = win_reg[r][1];
            win_next[r][1] = win_reg[r][2];
        end
        win_next[0][2] = ls_word[2*PIX_W-1:PIX_W];
        win_next[1][2] = ls_word[PIX_W-1:0];
        win_next[2][2] = s1_px_reg;
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
            win_reg <= win_next;
    end

    assign emit   = (32'(s1_row_reg) >= 32'd2) && (32'(s1_col_reg) >= 32'd2);
    assign push   = s1_valid_reg && emit;
    assign col_m1 = s1_col_reg - 1'b1;
    assign row_m1 = s1_row_reg - 1'b1;

    always_comb
    begin
        push_data.p00  = win_next[0][0];
        push_data.p01  = win_next[0][1];
        push_data.p02  = win_next[0][2];
        push_data.p10  = win_next[1][0];
        push_data.p12  = win_next[1][2];
        push_data.p20  = win_next[2][0];
        push_data.p21  = win_next[2][1];
        push_data.p22  = win_next[2][2];
        push_data.col  = POS_W'(col_m1);
        push_data.row  = POS_W'(row_m1);
        push_data.last = (32'(s1_row_reg) == 32'(size.height) - 32'd1) &&
                         (32'(s1_col_reg) == 32'(size.width) - 32'd1);
    end

    // an interior center never sits in row or column zero
    a_push_interior: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (col_m1 != '0) && (row_m1 != '0))
        else $error("window pushed for a border position");

    // back-to-back same column must take the forwarded word
    a_bypass: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && s1_valid_reg && (s1_col_reg == col_cur)) |=> byp_hit_reg)
        else $error("line store forward missed");

endmodule
`default_nettype wire

// ----- hdl/sbl_queue.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// sbl_queue
// short window queue between intake and gradient output
// ---------------------------------------------------------------------------
module sbl_queue
    import sbl_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire sbl_win_t          push_data,
    input  wire logic              pop,
    output logic                   q_valid,
    output sbl_win_t               q_data,
    output logic [QCNT_W-1:0]      q_count
);

    sbl_win_t            mem [QDEPTH];
    logic [QPTR_W-1:0]   head_reg, tail_reg;
    logic [QCNT_W-1:0]   count_reg;

    assign q_valid = (count_reg != '0);
    assign q_data  = mem[head_reg];
    assign q_count = count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
                tail_reg <= (32'(tail_reg) == QDEPTH - 1) ? '0 : tail_reg + 1'b1;
            if (pop)
                head_reg <= (32'(head_reg) == QDEPTH - 1) ? '0 : head_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[tail_reg] <= push_data;
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (32'(count_reg) < QDEPTH) || pop)
        else $error("queue overflow");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> q_valid)
        else $error("queue underflow");

endmodule
`default_nettype wire

// ----- hdl/sbl_back.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// sbl_back
// gradient arithmetic and output word register
// ---------------------------------------------------------------------------
module sbl_back
    import sbl_pkg::*;
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          q_valid,
    input  wire sbl_win_t      q_data,
    output logic               pop,
    output logic               m_tvalid,
    input  wire logic          m_tready,
    output logic [47:0]        m_tdata,
    output logic               m_tlast
);

    logic                m_tvalid_reg;
    logic [GRAD_W-2:0]   gx_pos, gx_neg, gy_pos, gy_neg;
    logic [GRAD_W-1:0]   gx, gy;
    logic [GRAD_W-1:0]   gx_reg, gy_reg;
    logic [POS_W-1:0]    col_reg, row_reg;
    logic                last_reg;

    assign pop = q_valid && (!m_tvalid_reg || m_tready);

    // weights 1,2,1 on each side; sides stay below 1021
    always_comb
    begin
        gx_pos = (GRAD_W-1)'(q_data.p02) + {1'b0, q_data.p12, 1'b0} + (GRAD_W-1)'(q_data.p22);
        gx_neg = (GRAD_W-1)'(q_data.p00) + {1'b0, q_data.p10, 1'b0} + (GRAD_W-1)'(q_data.p20);
        gy_pos = (GRAD_W-1)'(q_data.p20) + {1'b0, q_data.p21, 1'b0} + (GRAD_W-1)'(q_data.p22);
        gy_neg = (GRAD_W-1)'(q_data.p00) + {1'b0, q_data.p01, 1'b0} + (GRAD_W-1)'(q_data.p02);
        gx     = {1'b0, gx_pos} - {1'b0, gx_neg};
        gy     = {1'b0, gy_pos} - {1'b0, gy_neg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tvalid_reg <= 1'b0;
        else if (pop)
            m_tvalid_reg <= 1'b1;
        else if (m_tready)
            m_tvalid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            gx_reg   <= gx;
            gy_reg   <= gy;
            col_reg  <= q_data.col;
            row_reg  <= q_data.row;
            last_reg <= q_data.last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {6'd0, row_reg, col_reg, gy_reg, gx_reg};
    assign m_tlast  = last_reg;

    // a held word is never replaced by a new pop
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid_reg && !m_tready) |-> !pop)
        else $error("output word overwritten while stalled");

endmodule
`default_nettype wire

// ----- test/tb_sobel_gradient_3x3_core.sv -----
// ---------------------------------------------------------------------------
// tb_sobel_gradient_3x3_core
// self-checking bench for the streaming 3x3 sobel gradient core: a short table
// of hand-checked frames with typed-in results, then clamped frame sizes, a
// mid-frame size change and random frames with restarts scored word by word
// against an in-bench gradient predictor under random source and sink throttling
// ---------------------------------------------------------------------------
module tb_sobel_gradient_3x3_core
    import sbl_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // cycles to let the core settle before a register write and at the end
    localparam int QUIET_CYCLES = 8;
    // long sink stall, fills the output queue and blocks the pixel input
    localparam int HOLD_CYCLES  = 300;
    localparam int HOLD_AFTER   = 10;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int RAND_PIXELS  = 200;
    localparam int REPORT_MAX   = 10;

    // register indexes the core does not decode
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

    // throttle profiles: sender light / sink heavy, reversed, none
    localparam int FLOW_SINK_HEAVY = 0;
    localparam int FLOW_SRC_HEAVY  = 1;
    localparam int FLOW_FREE       = 2;

    // one gradient word as the core reports it
    typedef struct packed {
        logic signed [GRAD_W-1:0] gx;
        logic signed [GRAD_W-1:0] gy;
        logic [POS_W-1:0]         col;
        logic [POS_W-1:0]         row;
        logic                     last;
    } grad_word_t;

    // one pixel of the hand-written table, with the frame size it belongs to
    typedef struct packed {
        logic [PIX_W-1:0] pix;
        logic             start;
        logic [CFG_W-1:0] w;
        logic [CFG_W-1:0] h;
        logic             typed;
        grad_word_t       exp;
    } dir_row_t;

    // frame a (4x3): columns 0,255,255,0 -> horizontal extremes both ways
    // frame b (3x4): rows 0,255,255,0 -> vertical extremes both ways
    // every window of both frames carries its result typed in
    localparam dir_row_t DIR_TAB [24] = '{
        '{8'd0,   1'b1, 11'd4, 11'd3, 1'b0, '0},
        '{8'd255, 1'b0, 11'd4, 11'd3, 1'b0, '0},
        '{8'd255, 1'b0, 11'd4, 11'd3, 1'b0, '0},
        '{8'd0,   1'b0, 11'd4, 11'd3, 1'b0, '0},
        '{8'd0,   1'b0, 11'd4, 11'd3, 1'b0, '0},
        '{8'd255, 1'b0, 11'd4, 11'd3, 1'b0, '0},
        '{8'd255, 1'b0, 11'd4, 11'd3, 1'b0, '0},
        '{8'd0,   1'b0, 11'd4, 11'd3, 1'b0, '0},
        '{8'd0,   1'b0, 11'd4, 11'd3, 1'b0, '0},
        '{8'd255, 1'b0, 11'd4, 11'd3, 1'b0, '0},
        '{8'd255, 1'b0, 11'd4, 11'd3, 1'b1, '{11'sd1020, 11'sd0, 10'd1, 10'd1, 1'b0}},
        '{8'd0,   1'b0, 11'd4, 11'd3, 1'b1, '{-11'sd1020, 11'sd0, 10'd2, 10'd1, 1'b1}},
        '{8'd0,   1'b1, 11'd3, 11'd4, 1'b0, '0},
        '{8'd0,   1'b0, 11'd3, 11'd4, 1'b0, '0},
        '{8'd0,   1'b0, 11'd3, 11'd4, 1'b0, '0},
        '{8'd255, 1'b0, 11'd3, 11'd4, 1'b0, '0},
        '{8'd255, 1'b0, 11'd3, 11'd4, 1'b0, '0},
        '{8'd255, 1'b0, 11'd3, 11'd4, 1'b0, '0},
        '{8'd255, 1'b0, 11'd3, 11'd4, 1'b0, '0},
        '{8'd255, 1'b0, 11'd3, 11'd4, 1'b0, '0},
        '{8'd255, 1'b0, 11'd3, 11'd4, 1'b1, '{11'sd0, 11'sd1020, 10'd1, 10'd1, 1'b0}},
        '{8'd0,   1'b0, 11'd3, 11'd4, 1'b0, '0},
        '{8'd0,   1'b0, 11'd3, 11'd4, 1'b0, '0},
        '{8'd0,   1'b0, 11'd3, 11'd4, 1'b1, '{11'sd0, -11'sd1020, 10'd1, 10'd2, 1'b1}}
    };

    logic                 clk;
    logic                 rst_n     = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [7:0]           s_tdata   = '0;
    logic                 s_tuser   = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [47:0]          m_tdata;
    logic                 m_tlast;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_wdata = '0;

    // predictor state: two line stores, the 3x3 window, raster position
    logic [PIX_W-1:0] line_above2 [MAX_WIDTH];
    logic [PIX_W-1:0] line_above1 [MAX_WIDTH];
    logic [PIX_W-1:0] win [3][3];
    int unsigned      col_pos;
    int unsigned      row_pos;
    logic [CFG_W-1:0] cfg_width;
    logic [CFG_W-1:0] cfg_height;

    grad_word_t pending_grads [$];
    int         fail_count    = 0;
    int         grads_checked = 0;
    int         flow_mode     = FLOW_SINK_HEAVY;
    int         cycle_count   = 0;

    sobel_gradient_3x3_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),   // [7:0] pixel
        .s_tuser   (s_tuser),   // [0] frame_start
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),   // [10:0] grad_x, [21:11] grad_y, [31:22] out_col,
                                // [41:32] out_row
        .m_tlast   (m_tlast),   // last_of_frame
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // run-away guard
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("** sobel_gradient_3x3_core: FAILED **");
        $finish;
    end

    // idle percentage per side for the current throttle profile
    function automatic int idle_pct(input bit sink_side);
        case (flow_mode)
            FLOW_SINK_HEAVY: return sink_side ? 64 : 18;
            FLOW_SRC_HEAVY:  return sink_side ? 18 : 64;
            default:         return 0;
        endcase
    endfunction

    function automatic void report_fault(input string msg);
        fail_count++;
        if (fail_count <= REPORT_MAX)
            $display("%s", msg);
    endfunction

    // register value as the core uses it, held to 3..hi
    function automatic int unsigned size_in_use(input logic [CFG_W-1:0] raw,
                                                input int unsigned hi);
        if (raw < 3)
            return 3;
        if (raw > hi)
            return hi;
        return raw;
    endfunction

    // advance the predictor by one pixel; hit says whether a gradient word is due
    function automatic void predict_gradient(input logic [PIX_W-1:0] px, input bit start,
                                             output bit hit, output grad_word_t gw);
        int unsigned      wl;
        int unsigned      hl;
        int unsigned      c;
        int unsigned      r;
        logic [POS_W-1:0] idx;
        int               gx;
        int               gy;
        wl = size_in_use(cfg_width, MAX_WIDTH);
        hl = size_in_use(cfg_height, MAX_HEIGHT);
        if (start)
        begin
            col_pos = 0;
            row_pos = 0;
        end
        c = col_pos;
        r = row_pos;
        idx = c[POS_W-1:0];

        // shift the window left, new right column from the stores and the pixel
        for (int k = 0; k < 3; k++)
        begin
            win[k][0] = win[k][1];
            win[k][1] = win[k][2];
        end
        win[0][2] = line_above2[idx];
        win[1][2] = line_above1[idx];
        win[2][2] = px;
        line_above2[idx] = line_above1[idx];
        line_above1[idx] = px;

        hit = (r >= 2) && (c >= 2);
        gw = '0;
        if (hit)
        begin
            gx = (int'(win[0][2]) + 2 * int'(win[1][2]) + int'(win[2][2]))
               - (int'(win[0][0]) + 2 * int'(win[1][0]) + int'(win[2][0]));
            gy = (int'(win[2][0]) + 2 * int'(win[2][1]) + int'(win[2][2]))
               - (int'(win[0][0]) + 2 * int'(win[0][1]) + int'(win[0][2]));
            gw.gx   = gx[GRAD_W-1:0];
            gw.gy   = gy[GRAD_W-1:0];
            gw.col  = POS_W'(c - 1);
            gw.row  = POS_W'(r - 1);
            gw.last = (r == hl - 1) && (c == wl - 1);
        end

        // raster advance, wrapping past the size in use
        c++;
        if (c >= wl)
        begin
            c = 0;
            r++;
            if (r >= hl)
                r = 0;
        end
        col_pos = c;
        row_pos = r;
    endfunction

    // offer one pixel word and hold it until taken
    task automatic send_pixel(input logic [PIX_W-1:0] px, input bit start);
        while ($urandom_range(99) < idle_pct(1'b0))
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= px;
        s_tuser  <= start;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    task automatic feed_pixel(input logic [PIX_W-1:0] px, input bit start);
        bit         hit;
        grad_word_t gw;
        send_pixel(px, start);
        predict_gradient(px, start, hit, gw);
        if (hit)
            pending_grads.push_back(gw);
    endtask

    // one register write per cycle; the caller lowers cfg_we after the last one
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        if (idx == REG_FRAME_WIDTH)
            cfg_width = val;
        else if (idx == REG_FRAME_HEIGHT)
            cfg_height = val;
    endtask

    task automatic set_frame_size(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
        write_reg(REG_FRAME_WIDTH, w);
        write_reg(REG_FRAME_HEIGHT, h);
        cfg_we <= 1'b0;
    endtask

    // input already lowered by the caller; wait until every word is out
    task automatic wait_quiet();
        while (pending_grads.size() != 0)
            @(posedge clk);
        repeat (QUIET_CYCLES) @(posedge clk);
    endtask

    // a run of pixels; noisy adds stray frame starts, binary uses only 0 and 255
    task automatic run_frame(input bit with_start, input int len, input bit noisy,
                             input bit binary);
        logic [PIX_W-1:0] px;
        bit               st;
        for (int i = 0; i < len; i++)
        begin
            px = binary ? {PIX_W{1'($urandom_range(1))}} : PIX_W'($urandom_range(255));
            st = (i == 0 && with_start) || (noisy && i > 0 && $urandom_range(79) == 0);
            feed_pixel(px, st);
        end
    endtask

    // sink side: score each gradient word, then pick next cycle's tready
    initial
    begin
        grad_word_t seen;
        grad_word_t want;
        int         hold_left;
        bit         hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
            begin
                seen.gx   = m_tdata[10:0];
                seen.gy   = m_tdata[21:11];
                seen.col  = m_tdata[31:22];
                seen.row  = m_tdata[41:32];
                seen.last = m_tlast;
                grads_checked++;
                if (pending_grads.size() == 0)
                    report_fault($sformatf("unexpected word gx=%0d gy=%0d col=%0d row=%0d last=%0b",
                                           seen.gx, seen.gy, seen.col, seen.row, seen.last));
                else
                begin
                    want = pending_grads.pop_front();
                    if (seen.gx !== want.gx || seen.gy !== want.gy || seen.col !== want.col
                        || seen.row !== want.row || seen.last !== want.last)
                        report_fault($sformatf({"word mismatch: exp gx=%0d gy=%0d col=%0d row=%0d",
                                                " last=%0b, got gx=%0d gy=%0d col=%0d row=%0d",
                                                " last=%0b"},
                                               want.gx, want.gy, want.col, want.row, want.last,
                                               seen.gx, seen.gy, seen.col, seen.row, seen.last));
                end
            end
            // one long stall once the stream is going, to back up into s_tready
            if (!hold_done && grads_checked >= HOLD_AFTER)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= ($urandom_range(99) >= idle_pct(1'b1));
        end
    end

    // stimulus
    initial
    begin
        dir_row_t         row;
        bit               hit;
        grad_word_t       gw;
        int               rand_pixels;
        int               len;
        bit               fresh;
        logic [CFG_W-1:0] w_raw;
        logic [CFG_W-1:0] h_raw;

        // predictor reset state mirrors the core after reset
        cfg_width  = FRAME_WIDTH_RST;
        cfg_height = FRAME_HEIGHT_RST;
        col_pos    = 0;
        row_pos    = 0;
        for (int r = 0; r < 3; r++)
            for (int c = 0; c < 3; c++)
                win[r][c] = '0;
        for (int i = 0; i < MAX_WIDTH; i++)
        begin
            line_above2[i] = '0;
            line_above1[i] = '0;
        end

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // hand-checked frames, resized whenever a row opens a frame of new size
        flow_mode = FLOW_SINK_HEAVY;
        for (int i = 0; i < 24; i++)
        begin
            row = DIR_TAB[i];
            if (row.start && (row.w != cfg_width || row.h != cfg_height))
            begin
                s_tvalid <= 1'b0;
                wait_quiet();
                set_frame_size(row.w, row.h);
            end
            send_pixel(row.pix, row.start);
            predict_gradient(row.pix, row.start, hit, gw);
            if (row.typed)
                pending_grads.push_back(row.exp);
            else if (hit)
                pending_grads.push_back(gw);
        end

        // undecoded indexes, then width above range (full 1024) and height below (3)
        s_tvalid <= 1'b0;
        wait_quiet();
        write_reg(REG_SPARE_2, CFG_W'($urandom_range(2047)));
        write_reg(REG_SPARE_3, CFG_W'($urandom_range(2047)));
        set_frame_size(11'd2047, 11'd0);
        run_frame(1'b1, 40, 1'b0, 1'b0);

        // width below range (3), height at its maximum
        flow_mode = FLOW_SRC_HEAVY;
        s_tvalid <= 1'b0;
        wait_quiet();
        set_frame_size(11'd2, 11'(MAX_HEIGHT));
        run_frame(1'b1, 120, 1'b0, 1'b1);

        // shrink mid-frame: column past the new width, later row past the new height
        s_tvalid <= 1'b0;
        wait_quiet();
        set_frame_size(11'd8, 11'd6);
        run_frame(1'b1, 30, 1'b0, 1'b0);
        s_tvalid <= 1'b0;
        wait_quiet();
        write_reg(REG_FRAME_WIDTH, 11'd4);
        cfg_we <= 1'b0;
        run_frame(1'b0, 6, 1'b0, 1'b0);
        s_tvalid <= 1'b0;
        wait_quiet();
        write_reg(REG_FRAME_HEIGHT, 11'd3);
        cfg_we <= 1'b0;
        run_frame(1'b0, 20, 1'b0, 1'b0);

        // random frames: mostly complete small frames, some cut short or free-running
        rand_pixels = 0;
        while (rand_pixels < RAND_PIXELS)
        begin
            flow_mode = (rand_pixels < RAND_PIXELS / 3) ? FLOW_SINK_HEAVY :
                        (rand_pixels < 2 * RAND_PIXELS / 3) ? FLOW_SRC_HEAVY : FLOW_FREE;
            fresh = 1'b0;
            if ($urandom_range(9) < 6)
            begin
                if ($urandom_range(9) == 0)
                    w_raw = CFG_W'($urandom_range(2));
                else if ($urandom_range(5) == 0)
                    w_raw = CFG_W'($urandom_range(40, 3));
                else
                    w_raw = CFG_W'($urandom_range(12, 3));
                h_raw = ($urandom_range(9) == 0) ? CFG_W'($urandom_range(2))
                                                 : CFG_W'($urandom_range(8, 3));
                s_tvalid <= 1'b0;
                wait_quiet();
                set_frame_size(w_raw, h_raw);
                fresh = 1'b1;
            end
            len = size_in_use(cfg_width, MAX_WIDTH) * size_in_use(cfg_height, MAX_HEIGHT);
            if ($urandom_range(9) == 0)
                len = $urandom_range(len - 1, 1);
            // after a resize the frame must open with a start so the stores refill
            run_frame(fresh || $urandom_range(4) != 0, len, 1'b1, $urandom_range(3) == 0);
            rand_pixels += len;
        end

        s_tvalid <= 1'b0;
        while (pending_grads.size() != 0)
            @(posedge clk);
        repeat (QUIET_CYCLES) @(posedge clk);
        if (pending_grads.size() != 0)
            report_fault($sformatf("%0d gradient words never arrived", pending_grads.size()));

        if (fail_count == 0)
            $display("** sobel_gradient_3x3_core: PASSED **");
        else
            $display("** sobel_gradient_3x3_core: FAILED **");
        $finish;
    end

endmodule
